@@ src/rip_route_table_engine_defines.svh @@
// assertion macros used by the route table engine checker
`ifndef RIP_ROUTE_TABLE_ENGINE_DEFINES_SVH
`define RIP_ROUTE_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RRTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RRTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rrte_pkg.sv @@
// types, codes and helpers for the route table engine
package rrte_pkg;

	localparam int unsigned TABLE_DEPTH_DEFAULT = 32;
	localparam logic [7:0] INFINITY_RESET = 8'd16;
	localparam logic [7:0] RIP_VERSION = 8'd2;
	localparam logic [7:0] PKT_REQUEST = 8'd1;
	localparam logic [7:0] PKT_RESPONSE = 8'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_VERSION_ERR = 2'd1;
	localparam logic [1:0] ST_COMMAND_ERR = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ROUTE = 1'b1;

	typedef enum logic [1:0] {
		CMD_HEADER,
		CMD_ROUTE,
		CMD_TIMEOUT,
		CMD_ADVERTISE
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK_RD,
		S_LOOK_CMP,
		S_DUMP_RD,
		S_DUMP_CMP,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [7:0]  metric;
		logic [7:0]  iface;
	} entry_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [7:0]  metric;
		logic        last;
	} res_t;

	function automatic res_t make_status(logic [1:0] st);
		res_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		return r;
	endfunction

	function automatic res_t make_route(entry_t e);
		res_t r;
		r = '0;
		r.kind = KIND_ROUTE;
		r.status = ST_OK;
		r.dest = e.dest;
		r.mask = e.mask;
		r.hop = e.hop;
		r.metric = e.metric;
		return r;
	endfunction

endpackage

@@ src/rip_route_table_engine.sv @@
// RIPv2 route table engine: table memory, scan sequencer and result register
//
// Input channel (in_valid / in_stall): one beat per item, fields cmd .. iface.
// in_stall is high while an item is being worked on; the next item is taken
// only once the sequencer is back in idle.
// Output channel (out_valid / out_stall): one beat per result, last marks the
// final result of an item. Results sit in an output register, so the
// sequencer keeps scanning while one result waits to be taken.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes infinity_metric;
// cfg_ready is always high, and writes belong in idle time.
// Lookups and dumps walk the table through one memory read port, one entry
// at a time, with a read state and then a compare state per entry. A header
// error, a response header, or a zero destination skips the table walk.
// A stalled receiver holds the result register; the dump pauses when a
// second result is ready and resumes once the register is free.
// Reset (arst_n low) empties the table, clears all valids and sets
// infinity_metric to 16; the table memory itself is not cleared.
module rip_route_table_engine #(
	parameter int unsigned TABLE_DEPTH = rrte_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  pkt_version,
	input  logic [7:0]  pkt_command,
	input  logic [31:0] dest,
	input  logic [31:0] netmask,
	input  logic [31:0] metric_in,
	input  logic [31:0] sender_addr,
	input  logic [7:0]  iface,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [1:0]  status,
	output logic [31:0] route_dest,
	output logic [31:0] route_mask,
	output logic [31:0] route_next_hop,
	output logic [7:0]  route_metric,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	rrte_pkg::entry_t mem [TABLE_DEPTH];
	rrte_pkg::entry_t rd_data_q;
	rrte_pkg::entry_t wr_entry;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;

	rrte_pkg::state_t state_q, state_d;
	logic [CW-1:0]    idx_q, idx_d, idx_dec;
	logic [CW-1:0]    count_q, count_d;
	logic [7:0]       inf_q;

	rrte_pkg::cmd_t   cmd_q;
	logic [31:0]      dest_q, mask_q, mi_q, snd_q;
	logic [7:0]       iface_q;
	logic [7:0]       new_metric;

	logic             pend_valid_q, pend_valid_d;
	rrte_pkg::res_t   pend_q, pend_d;
	rrte_pkg::res_t   emit_res;
	logic             out_valid_q;
	rrte_pkg::res_t   out_q;
	logic             emit, emit_last, out_free, accept;
	logic             hit;

	assign in_stall = (state_q != rrte_pkg::S_IDLE);
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign idx_dec = idx_q - 1'b1;
	assign hit = (rd_data_q.dest == dest_q) && (rd_data_q.mask == mask_q);
	assign new_metric = (mi_q >= {24'd0, inf_q}) ? inf_q : (mi_q[7:0] + 8'd1);

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrte_pkg::S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			inf_q <= rrte_pkg::INFINITY_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
			pend_valid_q <= pend_valid_d;
			if (cfg_valid && cfg_ready) begin
				inf_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		emit_res = pend_q;
		emit_res.last = emit_last;
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (accept) begin
			cmd_q <= rrte_pkg::cmd_t'(cmd);
			dest_q <= dest;
			mask_q <= netmask;
			mi_q <= metric_in;
			snd_q <= sender_addr;
			iface_q <= iface;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		count_d = count_q;
		pend_valid_d = pend_valid_q;
		pend_d = pend_q;
		emit = 1'b0;
		emit_last = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_entry = rd_data_q;
		rd_addr = idx_q[AW-1:0];
		unique case (state_q)
			rrte_pkg::S_IDLE: begin
				if (accept) begin
					unique case (rrte_pkg::cmd_t'(cmd)) inside
						rrte_pkg::CMD_HEADER: begin
							pend_valid_d = 1'b1;
							state_d = rrte_pkg::S_FLUSH;
							if (pkt_version != rrte_pkg::RIP_VERSION) begin
								pend_d = rrte_pkg::make_status(rrte_pkg::ST_VERSION_ERR);
							end else if (pkt_command != rrte_pkg::PKT_REQUEST &&
								pkt_command != rrte_pkg::PKT_RESPONSE) begin
								pend_d = rrte_pkg::make_status(rrte_pkg::ST_COMMAND_ERR);
							end else begin
								pend_d = rrte_pkg::make_status(rrte_pkg::ST_OK);
								if (pkt_command == rrte_pkg::PKT_REQUEST) begin
									idx_d = count_q;
									state_d = rrte_pkg::S_DUMP_RD;
								end
							end
						end
						rrte_pkg::CMD_ROUTE, rrte_pkg::CMD_TIMEOUT: begin
							if (dest != 32'd0) begin
								idx_d = '0;
								state_d = rrte_pkg::S_LOOK_RD;
							end
						end
						rrte_pkg::CMD_ADVERTISE: begin
							pend_valid_d = 1'b0;
							idx_d = count_q;
							state_d = rrte_pkg::S_DUMP_RD;
						end
						default: begin
							state_d = rrte_pkg::S_IDLE;
						end
					endcase
				end
			end
			rrte_pkg::S_LOOK_RD: begin
				if (idx_q == count_q) begin
					state_d = rrte_pkg::S_IDLE;
					if (cmd_q == rrte_pkg::CMD_ROUTE) begin
						if (count_q == FULL_COUNT) begin
							pend_d = rrte_pkg::make_status(rrte_pkg::ST_TABLE_FULL);
							pend_valid_d = 1'b1;
							state_d = rrte_pkg::S_FLUSH;
						end else begin
							wr_en = 1'b1;
							wr_addr = count_q[AW-1:0];
							wr_entry = '{dest: dest_q, mask: mask_q, hop: snd_q,
								metric: new_metric, iface: iface_q};
							count_d = count_q + 1'b1;
						end
					end
				end else begin
					state_d = rrte_pkg::S_LOOK_CMP;
				end
			end
			rrte_pkg::S_LOOK_CMP: begin
				if (hit) begin
					state_d = rrte_pkg::S_IDLE;
					if (cmd_q == rrte_pkg::CMD_TIMEOUT) begin
						wr_en = 1'b1;
						wr_entry.metric = inf_q;
					end else if (rd_data_q.hop == snd_q) begin
						wr_en = 1'b1;
						wr_entry.metric = new_metric;
						wr_entry.iface = iface_q;
					end else if (mi_q < {24'd0, rd_data_q.metric}) begin
						wr_en = 1'b1;
						wr_entry.metric = new_metric;
						wr_entry.hop = snd_q;
						wr_entry.iface = iface_q;
					end
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = rrte_pkg::S_LOOK_RD;
				end
			end
			rrte_pkg::S_DUMP_RD: begin
				if (idx_q == '0) begin
					state_d = rrte_pkg::S_FLUSH;
				end else begin
					rd_addr = idx_dec[AW-1:0];
					idx_d = idx_dec;
					state_d = rrte_pkg::S_DUMP_CMP;
				end
			end
			rrte_pkg::S_DUMP_CMP: begin
				if (rd_data_q.iface == iface_q) begin
					state_d = rrte_pkg::S_DUMP_RD;
				end else if (!pend_valid_q || out_free) begin
					emit = pend_valid_q;
					pend_d = rrte_pkg::make_route(rd_data_q);
					pend_valid_d = 1'b1;
					state_d = rrte_pkg::S_DUMP_RD;
				end
			end
			rrte_pkg::S_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = rrte_pkg::S_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					emit_last = 1'b1;
					pend_valid_d = 1'b0;
					state_d = rrte_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rrte_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign status = out_q.status;
	assign route_dest = out_q.dest;
	assign route_mask = out_q.mask;
	assign route_next_hop = out_q.hop;
	assign route_metric = out_q.metric;
	assign last = out_q.last;

endmodule

@@ src/rrte_checker.sv @@
// port-level checker for the route table engine, bound to the top level
`include "rip_route_table_engine_defines.svh"

module rrte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [1:0]  status,
	input logic [31:0] route_dest,
	input logic [31:0] route_mask,
	input logic [31:0] route_next_hop,
	input logic [7:0]  route_metric,
	input logic        last
);

	`RRTE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({kind, status, route_dest, route_mask, route_next_hop, route_metric, last}), "stalled result beat changed")
	`RRTE_ASSERT_NOW(a_status_zero_route, clk, arst_n, out_valid && kind == rrte_pkg::KIND_STATUS, route_dest == 32'd0 && route_mask == 32'd0 && route_next_hop == 32'd0 && route_metric == 8'd0, "status beat carries route data")
	`RRTE_ASSERT_NOW(a_route_status_ok, clk, arst_n, out_valid && kind == rrte_pkg::KIND_ROUTE, status == rrte_pkg::ST_OK, "route beat carries nonzero status")
	`RRTE_ASSERT_NOW(a_error_is_last, clk, arst_n, out_valid && kind == rrte_pkg::KIND_STATUS && status != rrte_pkg::ST_OK, last, "error status beat not marked last")

endmodule

bind rip_route_table_engine rrte_checker u_rrte_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.status(status),
	.route_dest(route_dest),
	.route_mask(route_mask),
	.route_next_hop(route_next_hop),
	.route_metric(route_metric),
	.last(last)
);
